FILE: rtl/lcsu_pkg.sv
package lcsu_pkg;

	localparam int CFG_W = 10;
	localparam int ROW_W = 9;
	localparam int COL_W = 9;

	localparam int MIN_DIM     = 3;
	localparam int BIRTH_COUNT = 3;
	localparam int SURVIVE_MIN = 2;
	localparam int SURVIVE_MAX = 3;

	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic             next_alive;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} result_t;

	// B3/S23 on a 3x3 window, centre at bit 4
	function automatic logic next_state(input logic [8:0] win);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				n = n + {3'b000, win[i]};
			end
		end
		if (win[4]) begin
			return (n == 4'(SURVIVE_MIN)) || (n == 4'(SURVIVE_MAX));
		end
		return n == 4'(BIRTH_COUNT);
	endfunction

endpackage

FILE: rtl/lcsu_linebuf.sv
// Two line buffers side by side: bit 0 row above, bit 1 middle row
module lcsu_linebuf #(
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [1:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [1:0]               wr_data
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/life_cell_stream_update_unit.sv
// The word that completes a window is registered in stage 1; its result word is then registered in the output buffer.
// Throughput: one cell word per cycle while the output buffer can take results; each row end after the
// first row gives two results, the second leaving after the first is taken, and input stalls while both wait.
// Line buffers read one column per cycle, when a cell word is accepted, from a single RAM, registered read.
// Reset: asynchronous, active low; clears counters, window and handshake state,
// width and height return to 500. Line buffers are not cleared.
module life_cell_stream_update_unit
	import lcsu_pkg::*;
#(
	parameter int MAX_WIDTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] cell_alive
	input  logic        s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] next_alive, [9:1] out_row, [18:10] out_col
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int W_CAP = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;

	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic [CFG_W-1:0] w_eff, h_eff;
	logic [CFG_W-1:0] row_q, col_q;

	logic             in_acc, out_acc, cfg_wr;
	logic             row_end, frame_end, v_in;

	logic             valid_s1;
	logic             v_s1, row_end_s1, frame_end_s1;
	logic [CFG_W-1:0] row_s1, col_s1;
	logic [1:0]       rd_data;
	logic             a_bit, m_bit;
	logic [8:0]       window_q, base, win_new;
	logic             has_r, has0, has1;
	result_t          res_a, res_b, ld0, ld1;
	logic [1:0]       n_new;
	logic             s1_adv, s2_can_load;

	logic [1:0]       cnt_q;
	result_t          res0_q, res1_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_HEIGHT) ? 32'(grid_height_q)
	                                                      : 32'(grid_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(500);
			grid_height_q <= CFG_W'(500);
		end else if (cfg_wr) begin
			if (reg_idx_t'(paddr[2]) == REG_HEIGHT) begin
				grid_height_q <= pwdata[CFG_W-1:0];
			end else begin
				grid_width_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (grid_width_q < CFG_W'(MIN_DIM)) begin
			w_eff = CFG_W'(MIN_DIM);
		end else if (grid_width_q > CFG_W'(W_CAP)) begin
			w_eff = CFG_W'(W_CAP);
		end else begin
			w_eff = grid_width_q;
		end
		if (grid_height_q < CFG_W'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else begin
			h_eff = grid_height_q;
		end
	end

	// input side: raster position
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign row_end   = col_q >= (w_eff - CFG_W'(1));
	assign frame_end = row_q >= h_eff;
	assign v_in      = (s_axis_tuser == OP_CELL) && s_axis_tdata[0] && !frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + CFG_W'(1);
			end else begin
				col_q <= col_q + CFG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_s1         <= v_in;
			row_s1       <= row_q;
			col_s1       <= col_q;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	lcsu_linebuf #(
		.DEPTH(MAX_WIDTH)
	) u_linebuf (
		.clk    (clk),
		.rd_en  (in_acc),
		.rd_addr(AW'(col_q)),
		.rd_data(rd_data),
		.wr_en  (s1_adv),
		.wr_addr(AW'(col_s1)),
		.wr_data({v_s1, m_bit})
	);

	// window and results
	assign s2_can_load   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
	assign s1_adv        = valid_s1 && s2_can_load;
	assign s_axis_tready = !valid_s1 || s2_can_load;

	always_comb begin
		a_bit   = (row_s1 >= CFG_W'(2)) ? rd_data[0] : 1'b0;
		m_bit   = (row_s1 != '0) ? rd_data[1] : 1'b0;
		base    = (col_s1 == '0) ? 9'd0 : window_q;
		win_new = {v_s1, m_bit, a_bit, base[8:3]};
		has_r   = row_s1 != '0;
		has0    = has_r && (col_s1 != '0);
		has1    = has_r && row_end_s1;

		res_a.next_alive = next_state(win_new);
		res_a.row        = ROW_W'(row_s1 - CFG_W'(1));
		res_a.col        = COL_W'(col_s1 - CFG_W'(1));
		res_a.last       = 1'b0;

		res_b.next_alive = next_state({3'b000, win_new[8:3]});
		res_b.row        = ROW_W'(row_s1 - CFG_W'(1));
		res_b.col        = COL_W'(col_s1);
		res_b.last       = frame_end_s1;

		if (has0) begin
			ld0   = res_a;
			ld1   = res_b;
			n_new = has1 ? 2'd2 : 2'd1;
		end else begin
			ld0   = res_b;
			ld1   = res_b;
			n_new = has1 ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q <= win_new;
		end
	end

	// output buffer, up to two words
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (s1_adv) begin
			cnt_q <= n_new;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res0_q <= ld0;
			res1_q <= ld1;
		end else if (out_acc) begin
			res0_q <= res1_q;
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = {5'b00000, res0_q.col, res0_q.row, res0_q.next_alive};
	assign m_axis_tlast  = res0_q.last;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (cnt_q == 2'd1))
		else $error("frame end word not last in output buffer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (n_new == 2'd2)) |=> !s2_can_load)
		else $error("row end pair not given a stall cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		col_q < CFG_W'(W_CAP))
		else $error("column index past line buffer depth");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lcsu_pkg::*;

	localparam int LINE_DEPTH    = 512;
	localparam int LINE_AW       = $clog2(LINE_DEPTH);
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_CELLS  = 1030;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		opcode_t op;
		logic    alive;
	} cell_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [0] cell_alive
	logic        s_axis_tuser = 1'b0; // [0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [0] next_alive, [9:1] out_row, [18:10] out_col
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	life_cell_stream_update_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// generation engine mirror
	logic [CFG_W-1:0] grid_w = 10'd500;
	logic [CFG_W-1:0] grid_h = 10'd500;
	logic             above_line [LINE_DEPTH];
	logic             middle_line [LINE_DEPTH];
	logic [8:0]       window = '0;
	logic [CFG_W-1:0] row_idx = '0;
	logic [CFG_W-1:0] col_idx = '0;

	cell_word_t  cell_words [$];
	result_t     pending_next_states [$];
	int unsigned trk_row = 0;
	int unsigned trk_col = 0;
	int unsigned cells_queued = 0;
	int unsigned err_count = 0;
	bit          steady_flow = 1'b0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = grid_w;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = grid_h;
		if (h < MIN_DIM) h = MIN_DIM;
		return h;
	endfunction

	function automatic logic life_rule(input logic [8:0] win);
		int n;
		n = $countones(win) - win[4];
		if (win[4]) begin
			return (n == SURVIVE_MIN) || (n == SURVIVE_MAX);
		end
		return n == BIRTH_COUNT;
	endfunction

	task automatic step_life_cell(input opcode_t op, input logic alive);
		int unsigned w;
		int unsigned h;
		logic        v;
		logic        a;
		logic        m;
		result_t     res;
		w = eff_width();
		h = eff_height();
		v = (op == OP_CELL) ? alive : 1'b0;
		if (row_idx >= h) v = 1'b0;
		a = 1'b0;
		m = 1'b0;
		if (col_idx < LINE_DEPTH) begin
			a = above_line[col_idx[LINE_AW-1:0]];
			m = middle_line[col_idx[LINE_AW-1:0]];
			above_line[col_idx[LINE_AW-1:0]] = m;
			middle_line[col_idx[LINE_AW-1:0]] = v;
		end
		if (row_idx < 2) a = 1'b0;
		if (row_idx < 1) m = 1'b0;
		if (col_idx == 0) window = '0;
		window = {v, m, a, window[8:3]};
		if (row_idx >= 1 && col_idx >= 1) begin
			res.next_alive = life_rule(window);
			res.row        = ROW_W'(row_idx - 1);
			res.col        = COL_W'(col_idx - 1);
			res.last       = 1'b0;
			pending_next_states.push_back(res);
		end
		if (col_idx + 1 >= w) begin
			if (row_idx >= 1) begin
				res.next_alive = life_rule(window >> 3);
				res.row        = ROW_W'(row_idx - 1);
				res.col        = COL_W'(col_idx);
				res.last       = (row_idx >= h);
				pending_next_states.push_back(res);
			end
			col_idx = '0;
			row_idx = (row_idx >= h) ? '0 : row_idx + 1'b1;
		end else begin
			col_idx = col_idx + 1'b1;
		end
	endtask

	// queues cells until the frame closes or max_n words are out
	task automatic queue_frame_part(input int unsigned max_n, input int unsigned alive_pct,
			output bit frame_done);
		int unsigned n;
		int unsigned w;
		int unsigned h;
		cell_word_t  wd;
		frame_done = 1'b0;
		n = 0;
		while (!frame_done && n < max_n) begin
			w = eff_width();
			h = eff_height();
			if (trk_row < h) begin
				wd.op = ($urandom_range(0, 99) < 4) ? OP_FLUSH : OP_CELL;
			end else begin
				wd.op = ($urandom_range(0, 99) < 85) ? OP_FLUSH : OP_CELL;
			end
			wd.alive = ($urandom_range(0, 99) < alive_pct);
			cell_words.push_back(wd);
			n++;
			if (trk_col + 1 >= w) begin
				trk_col = 0;
				if (trk_row >= h) begin
					trk_row = 0;
					frame_done = 1'b1;
				end else begin
					trk_row++;
				end
			end else begin
				trk_col++;
			end
		end
		cells_queued += n;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (cell_words.size() != 0 || s_axis_tvalid || pending_next_states.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		trk_row = row_idx;
		trk_col = col_idx;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(32 - CFG_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH) begin
			grid_w = val;
		end else begin
			grid_h = val;
		end
	endtask

	task automatic report_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
		end
	endtask

	// cell word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				step_life_cell(opcode_t'(s_axis_tuser), s_axis_tdata[0]);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 11);
					s_axis_tvalid <= 1'b0;
				end else if (cell_words.size() != 0) begin
					cell_word_t wd;
					wd = cell_words.pop_front();
					s_axis_tdata  <= {7'd0, wd.alive};
					s_axis_tuser  <= wd.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result word monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_next_states.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("%0t: result word expected none actual %h last %b",
							$time, m_axis_tdata, m_axis_tlast);
					end
				end else begin
					result_t exp_r;
					exp_r = pending_next_states.pop_front();
					if (m_axis_tdata[0] !== exp_r.next_alive)
						report_field("next_alive", exp_r.next_alive, m_axis_tdata[0]);
					if (m_axis_tdata[9:1] !== exp_r.row)
						report_field("out_row", exp_r.row, m_axis_tdata[9:1]);
					if (m_axis_tdata[18:10] !== exp_r.col)
						report_field("out_col", exp_r.col, m_axis_tdata[18:10]);
					if (m_axis_tlast !== exp_r.last)
						report_field("last_of_frame", exp_r.last, m_axis_tlast);
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
				recv_stall <= $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [11:0]  dir_ops;
		logic [11:0]  dir_alive;
		cell_word_t   wd;
		bit           done;
		int unsigned  frame_no;
		int unsigned  pick;
		int unsigned  alive_pct;
		logic [CFG_W-1:0] new_w;
		logic [CFG_W-1:0] new_h;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 grid from undersized registers: flush inside the grid, live cell in the flush row
		write_reg(REG_WIDTH, 10'd0);
		write_reg(REG_HEIGHT, 10'd1);
		dir_ops   = 12'hA10;
		dir_alive = 12'h477;
		for (int i = 0; i < 12; i++) begin
			wd.op    = dir_ops[i] ? OP_FLUSH : OP_CELL;
			wd.alive = dir_alive[i];
			cell_words.push_back(wd);
		end
		wait_idle();

		// oversized width clamps to the line depth; then the row is cut short mid-frame
		write_reg(REG_WIDTH, 10'd1023);
		write_reg(REG_HEIGHT, 10'd0);
		queue_frame_part(600, 40, done);
		wait_idle();
		write_reg(REG_WIDTH, 10'd3);
		queue_frame_part(32'hFFFF_FFFF, 40, done);
		wait_idle();

		cells_queued = 0;
		frame_no = 0;
		while (cells_queued < RANDOM_CELLS) begin
			if (cells_queued >= RANDOM_CELLS - 300) steady_flow = 1'b1;
			if (frame_no == 0 || $urandom_range(0, 3) != 0) begin
				wait_idle();
				pick = $urandom_range(0, 99);
				if (pick < 8) new_w = CFG_W'($urandom_range(0, 2));
				else if (pick < 80) new_w = CFG_W'($urandom_range(3, 10));
				else if (pick < 95) new_w = CFG_W'($urandom_range(11, 40));
				else new_w = CFG_W'($urandom_range(41, 100));
				pick = $urandom_range(0, 99);
				if (pick < 8) new_h = CFG_W'($urandom_range(0, 2));
				else if (pick < 90) new_h = CFG_W'($urandom_range(3, 8));
				else new_h = CFG_W'($urandom_range(9, 20));
				if (frame_no == 0 || $urandom_range(0, 9) != 0) write_reg(REG_WIDTH, new_w);
				if (frame_no == 0 || $urandom_range(0, 9) != 0) write_reg(REG_HEIGHT, new_h);
			end
			pick = $urandom_range(0, 19);
			if (pick == 0) alive_pct = 0;
			else if (pick == 1) alive_pct = 100;
			else alive_pct = $urandom_range(15, 60);
			done = 1'b0;
			if (frame_no == 0 || $urandom_range(0, 3) == 0) begin
				// hold the stream mid-frame until drained, then maybe retune
				queue_frame_part($urandom_range(1, eff_width() * (eff_height() + 1) - 1),
					alive_pct, done);
				wait_idle();
				if (!done && $urandom_range(0, 2) != 0) begin
					new_w = CFG_W'($urandom_range(0, eff_width()));
					new_h = CFG_W'($urandom_range(0, 12));
					if ($urandom_range(0, 1)) write_reg(REG_WIDTH, new_w);
					if ($urandom_range(0, 1)) write_reg(REG_HEIGHT, new_h);
				end
			end
			if (!done) queue_frame_part(32'hFFFF_FFFF, alive_pct, done);
			frame_no++;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_next_states.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#15000000;
		$display("testbench failed");
		$finish;
	end

endmodule
